@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/cpf_pkg.sv @@
// Types, constants and encoding functions of the CP sequence framer.
package cpf_pkg;

    localparam logic [1:0] CMD_HEADER = 2'd0;
    localparam logic [1:0] CMD_MASK   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [2:0] REG_SHAPER_RATE = 3'd0;
    localparam logic [2:0] REG_SHAPER_IDENT = 3'd1;
    localparam logic [2:0] REG_COEF_A1 = 3'd2;
    localparam logic [2:0] REG_COEF_A2 = 3'd3;
    localparam logic [2:0] REG_COEF_B1 = 3'd4;
    localparam logic [2:0] REG_COEF_B2 = 3'd5;
    localparam logic [2:0] REG_CODEC_MASKS = 3'd6;

    localparam logic [2:0] FRM_OPEN   = 3'd0;
    localparam logic [2:0] FRM_INFO1  = 3'd1;
    localparam logic [2:0] FRM_INFO2  = 3'd2;
    localparam logic [2:0] FRM_INFO3  = 3'd3;
    localparam logic [2:0] FRM_INFO4  = 3'd4;
    localparam logic [2:0] FRM_INFO5  = 3'd5;
    localparam logic [2:0] FRM_INFO6  = 3'd6;
    localparam logic [2:0] FRM_INFO7  = 3'd7;
    localparam logic [2:0] FRM_CRC    = 3'd0;
    localparam logic [2:0] FRM_TRAILER = 3'd1;

    localparam logic [4:0]  FRAME_BITS   = 5'd17;
    localparam logic [4:0]  TRAILER_BITS = 5'd3;
    localparam logic [16:0] OPEN_FRAME   = 17'h1FFFF;
    localparam logic [15:0] CRC_POLY     = 16'h8408;
    localparam logic [15:0] CRC_SEED     = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic        rate_select_flag;
        logic        s_flag;
        logic        prime_flag;
        logic        c_flag;
        logic [12:0] info_field;
        logic [4:0]  data_rate;
        logic        cleardown;
        logic [15:0] level_q313;
        logic [23:0] group_numbers;
        logic [15:0] mask_word;
    } cpf_item_t;

    typedef struct packed {
        logic [16:0] frame_bits;
        logic [4:0]  bit_count;
        logic        last_of_run;
    } cpf_result_t;

    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [15:0] word);
        logic [15:0] r;
        logic        t;
        r = crc;
        for (int i = 0; i < 16; i++)
        begin
            t = word[i] ^ r[0];
            r = {1'b0, r[15:1]} ^ (t ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    // Greedy expansion; the low weights 16,16,8,4,2,1 saturate to all ones on overflow.
    function automatic logic [15:0] encode_level(logic [15:0] level);
        logic [1:0] hi;
        logic [3:0] lo;
        hi = level[5:4];
        lo = (hi == 2'd3) ? 4'hF : level[3:0];
        return {level[15:6], (hi != 2'd0), hi[1], lo};
    endfunction

    function automatic logic [7:0] encode_coef(logic [7:0] raw);
        logic [7:0] neg_val;
        logic [6:0] mag;
        neg_val = 8'd0 - raw;
        if (!raw[7])
        begin
            mag = raw[6:0];
        end
        else if (raw == 8'h80)
        begin
            mag = 7'h7F;
        end
        else
        begin
            mag = neg_val[6:0];
        end
        return {raw[7], mag};
    endfunction

endpackage

@@ hdl/cp_sequence_framer_crc16.sv @@
// CP sequence framer: turns header, mask-word and finish items into 17-bit frames.
// Path: the first frame of an item is built from the held-item register into the output register.
// Throughput: one frame per cycle while result_stall is low; a header gives 8 frames, a mask word 1,
// a finish 2, and every frame passes through the single output register.
// Reset: clears the CRC to all ones, the configuration registers and frame index to zero and both valid flags.
module cp_sequence_framer_crc16
    import cpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  cpf_item_t   item_data,
    output logic        result_valid,
    input  logic        result_stall,
    output cpf_result_t result_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  shaper_rate_reg;
    logic [1:0]  shaper_ident_reg;
    logic [7:0]  coef_a1_reg;
    logic [7:0]  coef_a2_reg;
    logic [7:0]  coef_b1_reg;
    logic [7:0]  coef_b2_reg;
    logic        codec_masks_reg;

    logic        held_valid_reg, held_valid_next;
    cpf_item_t   held_reg, held_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    cpf_result_t out_reg, out_next;

    logic        cfg_write;
    logic        item_take;
    logic        load;
    logic        last;
    logic [15:0] info_word;
    logic [4:0]  rate_sent;

    assign cfg_write = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[4:2])
            REG_SHAPER_RATE:  prdata = {30'd0, shaper_rate_reg};
            REG_SHAPER_IDENT: prdata = {30'd0, shaper_ident_reg};
            REG_COEF_A1:      prdata = {24'd0, coef_a1_reg};
            REG_COEF_A2:      prdata = {24'd0, coef_a2_reg};
            REG_COEF_B1:      prdata = {24'd0, coef_b1_reg};
            REG_COEF_B2:      prdata = {24'd0, coef_b2_reg};
            REG_CODEC_MASKS:  prdata = {31'd0, codec_masks_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shaper_rate_reg  <= 2'd0;
            shaper_ident_reg <= 2'd0;
            coef_a1_reg      <= 8'd0;
            coef_a2_reg      <= 8'd0;
            coef_b1_reg      <= 8'd0;
            coef_b2_reg      <= 8'd0;
            codec_masks_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_SHAPER_RATE:  shaper_rate_reg  <= pwdata[1:0];
                REG_SHAPER_IDENT: shaper_ident_reg <= pwdata[1:0];
                REG_COEF_A1:      coef_a1_reg      <= pwdata[7:0];
                REG_COEF_A2:      coef_a2_reg      <= pwdata[7:0];
                REG_COEF_B1:      coef_b1_reg      <= pwdata[7:0];
                REG_COEF_B2:      coef_b2_reg      <= pwdata[7:0];
                REG_CODEC_MASKS:  codec_masks_reg  <= pwdata[0];
                default:          ;
            endcase
        end
    end

    assign load = held_valid_reg & (~out_valid_reg | ~result_stall);
    assign rate_sent = held_reg.cleardown ? 5'd0 : held_reg.data_rate;

    always_comb
    begin
        case (held_reg.command)
            CMD_HEADER: last = (idx_reg == FRM_INFO7);
            CMD_FINISH: last = (idx_reg == FRM_TRAILER);
            default:    last = 1'b1;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            FRM_INFO1: info_word = {held_reg.prime_flag, shaper_rate_reg, held_reg.s_flag,
                                    5'd0, rate_sent, held_reg.rate_select_flag, 1'b0};
            FRM_INFO2: info_word = {shaper_ident_reg, held_reg.info_field, held_reg.c_flag};
            FRM_INFO3: info_word = encode_level(held_reg.level_q313);
            FRM_INFO4: info_word = {encode_coef(coef_a2_reg), encode_coef(coef_a1_reg)};
            FRM_INFO5: info_word = {encode_coef(coef_b2_reg), encode_coef(coef_b1_reg)};
            FRM_INFO6: info_word = held_reg.group_numbers[15:0];
            FRM_INFO7: info_word = {7'd0, codec_masks_reg, held_reg.group_numbers[23:16]};
            default:   info_word = 16'd0;
        endcase
    end

    assign item_stall = held_valid_reg & ~(load & last);
    assign item_take  = item_valid & ~item_stall;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        idx_next        = idx_reg;
        crc_next        = crc_reg;
        out_valid_next  = out_valid_reg & result_stall;
        out_next        = out_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            out_next.last_of_run = last;
            out_next.bit_count   = FRAME_BITS;
            idx_next = idx_reg + 3'd1;
            case (held_reg.command)
                CMD_HEADER:
                begin
                    if (idx_reg == FRM_OPEN)
                    begin
                        out_next.frame_bits = OPEN_FRAME;
                        crc_next = CRC_SEED;
                    end
                    else
                    begin
                        out_next.frame_bits = {info_word, 1'b0};
                        crc_next = crc_feed(crc_reg, info_word);
                    end
                end
                CMD_MASK:
                begin
                    out_next.frame_bits = {held_reg.mask_word, 1'b0};
                    crc_next = crc_feed(crc_reg, held_reg.mask_word);
                end
                default:
                begin
                    if (idx_reg == FRM_CRC)
                    begin
                        out_next.frame_bits = {crc_reg, 1'b0};
                    end
                    else
                    begin
                        out_next.frame_bits = 17'd0;
                        out_next.bit_count  = TRAILER_BITS;
                        crc_next = CRC_SEED;
                    end
                end
            endcase
            if (last)
            begin
                held_valid_next = 1'b0;
            end
        end

        if (item_take)
        begin
            held_next = item_data;
            idx_next  = 3'd0;
            held_valid_next = (item_data.command == CMD_HEADER) |
                              (item_data.command == CMD_MASK) |
                              (item_data.command == CMD_FINISH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            idx_reg        <= 3'd0;
            crc_reg        <= CRC_SEED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            idx_reg        <= idx_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

@@ hdl/cpf_checker.sv @@
// Port-level checker for the CP sequence framer and its bind statement.
`include "assert_macros.svh"

module cpf_checker
    import cpf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input cpf_result_t result_data
);

    `ASSERT_NEXT(a_valid_holds, clk, rst_n, result_valid && result_stall, result_valid)
    `ASSERT_NEXT(a_data_holds, clk, rst_n, result_valid && result_stall, $stable(result_data))
    `ASSERT_IMPLY(a_count_legal, clk, rst_n, result_valid, result_data.bit_count == FRAME_BITS || result_data.bit_count == TRAILER_BITS)
    `ASSERT_IMPLY(a_trailer_last, clk, rst_n, result_valid && result_data.bit_count == TRAILER_BITS, result_data.frame_bits == 17'd0 && result_data.last_of_run)
    `ASSERT_IMPLY(a_framing_zero, clk, rst_n, result_valid && result_data.frame_bits != OPEN_FRAME, !result_data.frame_bits[0])

endmodule

bind cp_sequence_framer_crc16 cpf_checker u_cpf_checker (.*);
